// ----- rtl/core/iis_pkg.sv -----
// Shared sizes, types and helpers for the integral image stream block.
package iis_pkg;

    // Largest frame the line store and counters are built for.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Field and state widths.
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 12;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ROWSUM_W = PIX_W + COL_W;
    localparam int SUM_W    = 30;

    // Register file.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } iis_reg_t;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(2048);

    // One pixel on its way from the scan counters to the line-store stage.
    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [ROWSUM_W-1:0] row_sum;
        logic                first_row;
        logic                row_end;
        logic                frame_end;
    } iis_item_t;

    // Last valid position for a size register: zero acts as one, oversize saturates.
    function automatic logic [31:0] last_pos(input logic [CFG_W-1:0] size, input int maxv);
        logic [31:0] v;
        v = 32'(size);
        if (v == 32'd0)
            return 32'd0;
        else if (v > 32'(maxv))
            return 32'(maxv) - 32'd1;
        else
            return v - 32'd1;
    endfunction

endpackage

// ----- rtl/core/iis_line_store.sv -----
// Previous-row integral line store: one write and one registered read per cycle.
module iis_line_store import iis_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output logic [SUM_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [SUM_W-1:0] wr_data
);

    logic [SUM_W-1:0] mem [MAX_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Bypass the word written on the same edge so a one-pixel row sees fresh data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/iis_scan_ctrl.sv -----
// Size registers, raster counters and the running row sum.
module iis_scan_ctrl import iis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [PIX_W-1:0]     pixel,
    output iis_item_t            item
);

    logic [CFG_W-1:0]    width_reg,   width_next;
    logic [CFG_W-1:0]    height_reg,  height_next;
    logic [COL_W-1:0]    col_reg,     col_next;
    logic [ROW_W-1:0]    row_reg,     row_next;
    logic [ROWSUM_W-1:0] row_sum_reg, row_sum_next;

    logic [COL_W-1:0]    last_col_pos;
    logic [ROW_W-1:0]    last_row_pos;
    logic [ROWSUM_W-1:0] sum_here;
    logic                last_col;
    logic                last_row;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (iis_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    assign last_col_pos = COL_W'(last_pos(width_reg, MAX_WIDTH));
    assign last_row_pos = ROW_W'(last_pos(height_reg, MAX_HEIGHT));
    assign last_col     = (col_reg >= last_col_pos);
    assign last_row     = (row_reg >= last_row_pos);
    assign sum_here     = row_sum_reg + ROWSUM_W'(pixel);

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        row_sum_next = row_sum_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next     = '0;
                row_sum_next = '0;
                row_next     = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next     = col_reg + COL_W'(1);
                row_sum_next = sum_here;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            row_sum_reg <= row_sum_next;
        end
    end

    always_comb
    begin
        item.col       = col_reg;
        item.row_sum   = sum_here;
        item.first_row = (row_reg == '0);
        item.row_end   = last_col;
        item.frame_end = last_col && last_row;
    end

endmodule

// ----- rtl/core/integral_image_stream.sv -----
// Integral image stream: top level with line-store stage and output register.
// A taken pixel fills stage 1 with its line-store read, then the output register with its result.
// Throughput: one pixel per cycle unless stalled; the line store reads and writes each cycle.
// A one-pixel row reads the column written on the same edge through a bypass.
// Reset (rst_n low, async): counters and row sum clear, sizes return to 2048, pipe empties.
// The line store is not cleared; the first row of a frame adds zero in place of its data.
module integral_image_stream import iis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // pixel beats in
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel,
    // result beats out
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SUM_W-1:0]     area_sum,
    output logic                 row_end,
    output logic                 frame_end
);

    logic             in_accept;
    iis_item_t        scan_item;

    // stage 1: line-store read data arrives here
    logic             s1_valid_reg, s1_valid_next;
    iis_item_t        s1_item_reg;
    logic             s1_adv;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] total;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] area_sum_reg;
    logic             row_end_reg;
    logic             frame_end_reg;
    logic             out_ready;

    // Back-pressure: the output register frees when empty or taken this edge,
    // and stage 1 frees when it moves into the output register.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    // Counters hand over the column, the row sum through this pixel and the end flags.
    iis_scan_ctrl u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .pixel     (pixel),
        .item      (scan_item)
    );

    // Read the column on accept, write the finished sum back when stage 1 advances.
    iis_line_store u_line
    (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (scan_item.col),
        .rd_data (above),
        .wr_en   (s1_adv),
        .wr_addr (s1_item_reg.col),
        .wr_data (total)
    );

    // The row above does not exist on the first row of a frame: add zero there.
    assign total = SUM_W'(s1_item_reg.row_sum) + (s1_item_reg.first_row ? '0 : above);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: advance with the handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= scan_item;
        if (s1_adv)
        begin
            area_sum_reg  <= total;
            row_end_reg   <= s1_item_reg.row_end;
            frame_end_reg <= s1_item_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign area_sum  = area_sum_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

`ifndef SYNTHESIS
    // A new pixel never lands on an occupied stage 1 that is not moving on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (!s1_valid_reg || s1_adv))
        else $error("pixel accepted over a held stage 1 entry");

    // The frame ends only on the last pixel of a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (!s1_item_reg.frame_end || s1_item_reg.row_end))
        else $error("frame end without row end");

    // On the first row the result is the row sum alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.first_row) |-> (total == SUM_W'(s1_item_reg.row_sum)))
        else $error("first row picked up line store data");

    // A result that moves forward is written to the output register on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_valid_reg && (area_sum_reg == $past(total))))
        else $error("stage 1 result not captured");
`endif

endmodule
